// File: sv/linear_blend_skinning_defines.svh
// Assertion macros for the bound checker lbs_chk.
`ifndef LINEAR_BLEND_SKINNING_DEFINES_SVH
`define LINEAR_BLEND_SKINNING_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LBS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lbs check failed");

// Consequent must hold in the cycle after the antecedent.
`define LBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lbs check failed");

`endif

// File: sv/lbs_pkg.sv
package lbs_pkg;

  // Palette geometry
  localparam int unsigned BONES     = 64;
  localparam int unsigned PAL_DEPTH = BONES * 16;
  localparam int unsigned PAL_AW    = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;

  // Datapath widths
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ACC_W       = 48;
  localparam int unsigned DOT_W       = 50;
  localparam int unsigned WGT_W       = 17;
  localparam int unsigned MUL_W       = 33;
  localparam int unsigned PROD_W      = 2 * MUL_W;
  localparam int unsigned SPLIT_W     = 24;
  localparam int unsigned LO_W        = SPLIT_W + WGT_W;
  localparam int unsigned IN_TDATA_W  = 192;
  localparam int unsigned OUT_TDATA_W = 96;

  localparam logic [WGT_W-1:0] WEIGHT_ONE = WGT_W'(65536);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ADD,
    ST_SAT,
    ST_WLO,
    ST_WHI,
    ST_UPD,
    ST_OUT
  } lbs_state_e;

  typedef enum logic [1:0] {
    MUL_TERM,
    MUL_WLO,
    MUL_WHI
  } mul_sel_e;

  // Sequencer to datapath controls
  typedef struct packed {
    logic       load;
    logic       mul_en;
    mul_sel_e   mul_sel;
    logic       dot_clr;
    logic       dot_add;
    logic       dot_sat;
    logic       lo_ld;
    logic       acc_upd;
    logic       out_ld;
    logic [1:0] row;
    logic [1:0] col;
  } lbs_ctrl_t;

  // Clamp a 50-bit signed value to 48 bits
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [DOT_W-1:0] v);
    logic [DOT_W-ACC_W:0] top;
    top = v[DOT_W-1:ACC_W-1];
    if ((top == '0) || (top == '1)) begin
      return v[ACC_W-1:0];
    end else if (v[DOT_W-1]) begin
      return {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      return {1'b0, {(ACC_W-1){1'b1}}};
    end
  endfunction

  // Clamp a 48-bit accumulator to 32 bits; msb of the result flags a clamp
  function automatic logic [DATA_W:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-DATA_W:0] top;
    top = v[ACC_W-1:DATA_W-1];
    if ((top == '0) || (top == '1)) begin
      return {1'b0, v[DATA_W-1:0]};
    end else if (v[ACC_W-1]) begin
      return {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

// File: sv/lbs_ram.sv
module lbs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/lbs_ctrl.sv
module lbs_ctrl
  import lbs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_mode_i,
  input  logic              in_last_i,
  input  logic [5:0]        in_bone_i,
  input  logic              bone_ok_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [PAL_AW-1:0] rd_addr_o,
  output lbs_ctrl_t         ctrl_o
);

  lbs_state_e state_q, state_d;
  logic [1:0] row_q, col_q;
  logic [5:0] bone_q;
  logic       last_q;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;
  logic [1:0] rd_col;

  assign accept   = in_valid_i && (state_q == ST_IDLE) && in_mode_i;
  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (bone_ok_i) begin
            state_d = ST_READ;
          end else if (in_last_i) begin
            state_d = ST_OUT;
          end
        end
      end
      ST_READ: state_d = ST_MUL;
      ST_MUL:  state_d = ST_ADD;
      ST_ADD:  state_d = (col_q == 2'd3) ? ST_SAT : ST_MUL;
      ST_SAT:  state_d = ST_WLO;
      ST_WLO:  state_d = ST_WHI;
      ST_WHI:  state_d = ST_UPD;
      ST_UPD: begin
        if (row_q != 2'd2) begin
          state_d = ST_READ;
        end else if (last_q) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT:  state_d = out_free ? ST_IDLE : ST_OUT;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    ctrl_o         = '0;
    ctrl_o.mul_sel = MUL_TERM;
    ctrl_o.row     = row_q;
    ctrl_o.col     = col_q;
    ctrl_o.load    = accept;
    case (state_q)
      ST_READ: ctrl_o.dot_clr = 1'b1;
      ST_MUL: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MUL_TERM;
      end
      ST_ADD:  ctrl_o.dot_add = 1'b1;
      ST_SAT:  ctrl_o.dot_sat = 1'b1;
      ST_WLO: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MUL_WLO;
      end
      ST_WHI: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MUL_WHI;
        ctrl_o.lo_ld   = 1'b1;
      end
      ST_UPD:  ctrl_o.acc_upd = 1'b1;
      ST_OUT:  ctrl_o.out_ld  = out_free;
      default: ;
    endcase
  end

  // Palette read: the add cycle fetches the next column ahead
  assign rd_col    = (state_q == ST_ADD) ? (col_q + 2'd1) : col_q;
  assign rd_addr_o = PAL_AW'({bone_q, row_q, rd_col});

  assign out_valid_d = ctrl_o.out_ld ? 1'b1 : (out_valid_q && !out_ready_i);

  // State and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      bone_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        row_q  <= '0;
        col_q  <= '0;
        bone_q <= in_bone_i;
        last_q <= in_last_i;
      end else if (state_q == ST_ADD) begin
        col_q <= col_q + 2'd1;
      end else if (state_q == ST_UPD) begin
        row_q <= row_q + 2'd1;
        col_q <= '0;
      end
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: sv/lbs_dp.sv
module lbs_dp
  import lbs_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lbs_ctrl_t                ctrl_i,
  input  logic signed [DATA_W-1:0] pos_x_i,
  input  logic signed [DATA_W-1:0] pos_y_i,
  input  logic signed [DATA_W-1:0] pos_z_i,
  input  logic signed [DATA_W-1:0] pos_w_i,
  input  logic [WGT_W-1:0]         weight_i,
  input  logic [DATA_W-1:0]        rdata_i,
  output logic signed [DATA_W-1:0] out_x_o,
  output logic signed [DATA_W-1:0] out_y_o,
  output logic signed [DATA_W-1:0] out_z_o,
  output logic                     overflow_o
);

  logic signed [DATA_W-1:0] pos_q [4];
  logic [WGT_W-1:0]         wgt_q;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic [LO_W-1:0]          lo_q;
  logic signed [DOT_W-1:0]  dot_q, term;
  logic signed [ACC_W-1:0]  dot_sat;
  logic signed [ACC_W-1:0]  acc_q [3];
  logic signed [PROD_W-1:0] wsum;
  logic signed [DOT_W-1:0]  acc_sum;
  logic [DATA_W:0]          sx, sy, sz;
  logic signed [DATA_W-1:0] ox_q, oy_q, oz_q;
  logic                     ovf_q;

  // Shared multiplier operand select
  always_comb begin
    case (ctrl_i.mul_sel)
      MUL_TERM: begin
        mul_a = MUL_W'($signed(rdata_i));
        mul_b = MUL_W'(pos_q[ctrl_i.col]);
      end
      MUL_WLO: begin
        mul_a = $signed({{(MUL_W-SPLIT_W){1'b0}}, dot_q[SPLIT_W-1:0]});
        mul_b = $signed({{(MUL_W-WGT_W){1'b0}}, wgt_q});
      end
      MUL_WHI: begin
        mul_a = MUL_W'($signed(dot_q[ACC_W-1:SPLIT_W]));
        mul_b = $signed({{(MUL_W-WGT_W){1'b0}}, wgt_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Term floor(m * p / 2^16), then dot clamp
  assign term    = DOT_W'($signed(prod_q[63:16]));
  assign dot_sat = sat_acc(dot_q);

  // Weighted contribution: high partial shifted onto the low one, floor by 2^16
  assign wsum    = (prod_q <<< SPLIT_W) + $signed({{(PROD_W-LO_W){1'b0}}, lo_q});
  assign acc_sum = DOT_W'(acc_q[ctrl_i.row]) + $signed(wsum[PROD_W-1:16]);

  assign sx = sat_out(acc_q[0]);
  assign sy = sat_out(acc_q[1]);
  assign sz = sat_out(acc_q[2]);

  // Operand, product, partial product, dot product and output registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      pos_q[0] <= pos_x_i;
      pos_q[1] <= pos_y_i;
      pos_q[2] <= pos_z_i;
      pos_q[3] <= pos_w_i;
      wgt_q    <= (weight_i > WEIGHT_ONE) ? WEIGHT_ONE : weight_i;
    end
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.lo_ld) begin
      lo_q <= prod_q[LO_W-1:0];
    end
    if (ctrl_i.dot_clr) begin
      dot_q <= '0;
    end else if (ctrl_i.dot_add) begin
      dot_q <= dot_q + term;
    end else if (ctrl_i.dot_sat) begin
      dot_q <= DOT_W'(dot_sat);
    end
    if (ctrl_i.out_ld) begin
      ox_q  <= sx[DATA_W-1:0];
      oy_q  <= sy[DATA_W-1:0];
      oz_q  <= sz[DATA_W-1:0];
      ovf_q <= sx[DATA_W] | sy[DATA_W] | sz[DATA_W];
    end
  end

  // Vertex accumulators, cleared as the result is loaded into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q[0] <= '0;
      acc_q[1] <= '0;
      acc_q[2] <= '0;
    end else if (ctrl_i.out_ld) begin
      acc_q[0] <= '0;
      acc_q[1] <= '0;
      acc_q[2] <= '0;
    end else if (ctrl_i.acc_upd) begin
      acc_q[ctrl_i.row] <= sat_acc(acc_sum);
    end
  end

  assign out_x_o    = ox_q;
  assign out_y_o    = oy_q;
  assign out_z_o    = oz_q;
  assign overflow_o = ovf_q;

endmodule

// File: sv/linear_blend_skinning.sv
// Linear blend skinning engine with a 64-bone palette of 4x4 Q16.16 matrices.
// A request with tuser = 0 writes one palette element and leaves tready high.
// A request with tuser = 1 applies one bone influence to the vertex held in the
// x, y and z accumulators. One shared 33x33 multiplier works through it, so
// tready stays low until the influence is done. Each matrix row runs through
// one palette read, four multiply-add pairs, a clamp, and two weight partial
// products with the update. An influence with tlast set then loads the result
// register, and waits there while a previous result is still not taken. The
// palette is a single-port-write, registered-read memory; an entry must be
// written before any influence uses it.
module linear_blend_skinning
  import lbs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // bone_index, matrix_row, matrix_col, matrix_value, pos_x, pos_y, pos_z,
  // pos_w, weight, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // mode
  input  logic                   s_axis_tuser,
  // last_influence
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // out_x, out_y, out_z
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // overflow
  output logic                   m_axis_tuser
);

  logic [5:0]               bone_index;
  logic [1:0]               matrix_row, matrix_col;
  logic [DATA_W-1:0]        matrix_value;
  logic signed [DATA_W-1:0] pos_x, pos_y, pos_z, pos_w;
  logic [WGT_W-1:0]         weight;
  logic                     bone_ok;
  logic                     pal_we;
  logic [PAL_AW-1:0]        pal_waddr, pal_raddr;
  logic [DATA_W-1:0]        pal_rdata;
  lbs_ctrl_t                ctrl;
  logic signed [DATA_W-1:0] out_x, out_y, out_z;

  // Request unpacking
  assign bone_index   = s_axis_tdata[5:0];
  assign matrix_row   = s_axis_tdata[7:6];
  assign matrix_col   = s_axis_tdata[9:8];
  assign matrix_value = s_axis_tdata[41:10];
  assign pos_x        = $signed(s_axis_tdata[73:42]);
  assign pos_y        = $signed(s_axis_tdata[105:74]);
  assign pos_z        = $signed(s_axis_tdata[137:106]);
  assign pos_w        = $signed(s_axis_tdata[169:138]);
  assign weight       = s_axis_tdata[186:170];

  assign bone_ok = (32'(bone_index) < BONES);

  // Palette write on a mode-0 request
  assign pal_we    = s_axis_tvalid && s_axis_tready && !s_axis_tuser && bone_ok;
  assign pal_waddr = PAL_AW'({bone_index, matrix_row, matrix_col});

  lbs_ram #(
    .Width(DATA_W),
    .Depth(PAL_DEPTH)
  ) u_palette (
    .clk_i,
    .we_i   (pal_we),
    .waddr_i(pal_waddr),
    .wdata_i(matrix_value),
    .raddr_i(pal_raddr),
    .rdata_o(pal_rdata)
  );

  lbs_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_last_i  (s_axis_tlast),
    .in_bone_i  (bone_index),
    .bone_ok_i  (bone_ok),
    .in_ready_o (s_axis_tready),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .rd_addr_o  (pal_raddr),
    .ctrl_o     (ctrl)
  );

  lbs_dp u_dp (
    .clk_i,
    .rst_ni,
    .ctrl_i    (ctrl),
    .pos_x_i   (pos_x),
    .pos_y_i   (pos_y),
    .pos_z_i   (pos_z),
    .pos_w_i   (pos_w),
    .weight_i  (weight),
    .rdata_i   (pal_rdata),
    .out_x_o   (out_x),
    .out_y_o   (out_y),
    .out_z_o   (out_z),
    .overflow_o(m_axis_tuser)
  );

  assign m_axis_tdata = {out_z, out_y, out_x};

endmodule

// File: sv/lbs_chk.sv
`include "linear_blend_skinning_defines.svh"

module lbs_chk
  import lbs_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   s_axis_tuser,
  input logic                   s_axis_tlast,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser
);

  // An accepted influence leaves the engine busy
  `LBS_ASSERT_NEXT(a_busy_after_influence, s_axis_tvalid && s_axis_tready && s_axis_tuser, !s_axis_tready)

  // A palette write leaves the engine free
  `LBS_ASSERT_NEXT(a_free_after_write, s_axis_tvalid && s_axis_tready && !s_axis_tuser, s_axis_tready)

  // A new result only comes out of a busy spell
  `LBS_ASSERT_NOW(a_result_after_work, $rose(m_axis_tvalid), $past(!s_axis_tready))

  // A stalled result holds
  `LBS_ASSERT_NEXT(a_result_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind linear_blend_skinning lbs_chk u_lbs_chk (.*);

// File: verif/lbs_tb_pkg.sv
package lbs_tb_pkg;
  import lbs_pkg::*;

  // Request kind carried on s_axis_tuser
  typedef enum logic {
    REQ_PALETTE   = 1'b0,
    REQ_INFLUENCE = 1'b1
  } skin_mode_e;

  // s_axis_tdata layout, lowest field last in the list
  typedef struct packed {
    logic [IN_TDATA_W-6-4-5*DATA_W-WGT_W-1:0] pad;
    logic [WGT_W-1:0]  weight;
    logic [DATA_W-1:0] pos_w;
    logic [DATA_W-1:0] pos_z;
    logic [DATA_W-1:0] pos_y;
    logic [DATA_W-1:0] pos_x;
    logic [DATA_W-1:0] value;
    logic [1:0]        col;
    logic [1:0]        row;
    logic [5:0]        bone;
  } skin_req_t;

  // m_axis_tdata layout
  typedef struct packed {
    logic [DATA_W-1:0] z;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] x;
  } skin_vert_t;

endpackage

// File: verif/lbs_skin_checker.sv
module lbs_skin_checker
  import lbs_pkg::*;
  import lbs_tb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // bone_index, matrix_row, matrix_col, matrix_value, pos_x, pos_y, pos_z,
  // pos_w, weight, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // mode
  input  logic                   s_axis_tuser,
  input  logic                   s_axis_tlast,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // out_x, out_y, out_z
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // overflow
  input  logic                   m_axis_tuser,
  output int                     err_cnt_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    skin_vert_t pos;
    logic       ovf;
  } skin_result_t;

  // Shadow palette and vertex accumulators
  logic [DATA_W-1:0] pal_mem [PAL_DEPTH];
  longint            vert_acc [3];
  skin_result_t      expected_verts [$];

  skin_req_t    req_seen;
  skin_result_t due;
  skin_vert_t   got;

  function automatic longint clamp_bits(input longint v, input int bits, output bit hit);
    longint hi;
    longint lo;
    hi  = (longint'(1) <<< (bits - 1)) - 1;
    lo  = -hi - 1;
    hit = 1'b0;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // One influence: weighted rows 0..2 of the bone matrix into x, y, z
  task automatic apply_influence(input skin_req_t rq, input logic last);
    longint            pos [4];
    longint            w;
    longint            dot;
    longint            m;
    bit                hit;
    bit                any_hit;
    logic [DATA_W-1:0] comp [3];
    skin_result_t      res;
    pos[0] = longint'($signed(rq.pos_x));
    pos[1] = longint'($signed(rq.pos_y));
    pos[2] = longint'($signed(rq.pos_z));
    pos[3] = longint'($signed(rq.pos_w));
    // weights above one saturate to one
    if (rq.weight > WEIGHT_ONE) begin
      w = longint'(WEIGHT_ONE);
    end else begin
      w = longint'(rq.weight);
    end
    for (int r = 0; r < 3; r++) begin
      dot = 0;
      if (rq.bone < BONES) begin
        for (int c = 0; c < 4; c++) begin
          m   = longint'($signed(pal_mem[{rq.bone, 2'(r), 2'(c)}]));
          dot = dot + ((m * pos[c]) >>> 16);
        end
      end
      dot         = clamp_bits(dot, ACC_W, hit);
      vert_acc[r] = clamp_bits(vert_acc[r] + ((dot * w) >>> 16), ACC_W, hit);
    end
    if (last) begin
      any_hit = 1'b0;
      for (int r = 0; r < 3; r++) begin
        comp[r]     = DATA_W'(clamp_bits(vert_acc[r], DATA_W, hit));
        any_hit     = any_hit | hit;
        vert_acc[r] = 0;
      end
      res.pos.x = comp[0];
      res.pos.y = comp[1];
      res.pos.z = comp[2];
      res.ovf   = any_hit;
      expected_verts = {expected_verts, res};
    end
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] seen);
    if (want !== seen) begin
      err_cnt_o++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
    end
  endtask

  // Predict on accepted requests, compare on accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vert_acc  = '{0, 0, 0};
      expected_verts.delete();
      err_cnt_o = 0;
      pending_o = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        req_seen = s_axis_tdata;
        if (s_axis_tuser == REQ_INFLUENCE) begin
          apply_influence(req_seen, s_axis_tlast);
        end else if (req_seen.bone < BONES) begin
          pal_mem[{req_seen.bone, req_seen.row, req_seen.col}] = req_seen.value;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_verts.size() == 0) begin
          err_cnt_o++;
          $display("%0t: unexpected result, expected none, actual %h ovf %b",
                   $time, m_axis_tdata, m_axis_tuser);
        end else begin
          due = expected_verts.pop_front();
          check_field("out_x", due.pos.x, got.x);
          check_field("out_y", due.pos.y, got.y);
          check_field("out_z", due.pos.z, got.z);
          check_field("overflow", DATA_W'(due.ovf), DATA_W'(m_axis_tuser));
        end
      end
      pending_o = expected_verts.size();
    end
  end

endmodule

// File: verif/tb_linear_blend_skinning.sv
module tb_linear_blend_skinning
  import lbs_pkg::*;
  import lbs_tb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_REQS    = 1150;
  localparam int HOLD_AT   = 12;
  localparam int HOLD_CYCS = 400;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  int                     err_cnt;
  int                     pending_cnt;

  // Stimulus bookkeeping
  int          n_sent  = 0;
  int          n_taken = 0;
  logic        calm;
  logic [15:0] written [BONES] = '{default: '0};
  bit          usable [BONES];
  int          usable_bones [$];

  always begin
    #5;
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
  end

  linear_blend_skinning u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  lbs_skin_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .err_cnt_o     (err_cnt),
    .pending_o     (pending_cnt)
  );

  // Q16.16 value: mostly small, some full range, some extremes
  function automatic logic [31:0] q16_value(input bit wide);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          default: return 32'h0001_0000;
        endcase
      end
      1, 2:    return $urandom;
      default: begin
        if (wide) begin
          return $urandom_range(0, 1 << 20) - (1 << 19);
        end
        return $urandom_range(0, 1 << 17) - (1 << 16);
      end
    endcase
  endfunction

  function automatic logic [WGT_W-1:0] rand_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return WEIGHT_ONE;
      2:       return WGT_W'($urandom_range(65537, 131071));
      default: return WGT_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // Request with every field random, pad kept at zero
  function automatic skin_req_t rand_req();
    skin_req_t rq;
    rq.pad    = '0;
    rq.weight = WGT_W'($urandom);
    rq.pos_w  = $urandom;
    rq.pos_z  = $urandom;
    rq.pos_y  = $urandom;
    rq.pos_x  = $urandom;
    rq.value  = $urandom;
    rq.col    = 2'($urandom);
    rq.row    = 2'($urandom);
    rq.bone   = 6'($urandom);
    return rq;
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_req(input skin_mode_e mode, input skin_req_t rq, input logic last);
    int gap;
    int b;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rq;
    s_axis_tuser  <= mode;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
    // a bone may be applied once rows 0..2 are all written
    if (mode == REQ_PALETTE) begin
      b = int'(rq.bone);
      written[b][{rq.row, rq.col}] = 1'b1;
      if (!usable[b] && written[b][11:0] == 12'hFFF) begin
        usable[b] = 1'b1;
        usable_bones = {usable_bones, b};
      end
    end
  endtask

  task automatic palette_write(input int bone, input int row, input int col,
                               input logic [31:0] val);
    skin_req_t rq;
    rq       = rand_req();
    rq.bone  = 6'(bone);
    rq.row   = 2'(row);
    rq.col   = 2'(col);
    rq.value = val;
    send_req(REQ_PALETTE, rq, 1'($urandom));
  endtask

  task automatic influence(input int bone, input logic [31:0] px, input logic [31:0] py,
                           input logic [31:0] pz, input logic [31:0] pw,
                           input logic [WGT_W-1:0] wt, input logic last);
    skin_req_t rq;
    rq        = rand_req();
    rq.bone   = 6'(bone);
    rq.pos_x  = px;
    rq.pos_y  = py;
    rq.pos_z  = pz;
    rq.pos_w  = pw;
    rq.weight = wt;
    send_req(REQ_INFLUENCE, rq, last);
  endtask

  task automatic load_matrix(input int bone);
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        palette_write(bone, r, c, q16_value(c == 3));
      end
    end
  endtask

  // One vertex: 1..4 influences, now and then a palette write in between
  task automatic vertex();
    int n;
    int b;
    logic [31:0] pw;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        palette_write($urandom_range(0, BONES - 1), $urandom_range(0, 3),
                      $urandom_range(0, 3), q16_value(1'b1));
      end
      b  = usable_bones[$urandom_range(0, usable_bones.size() - 1)];
      pw = ($urandom_range(0, 3) == 0) ? q16_value(1'b1) : 32'h0001_0000;
      influence(b, q16_value(1'b1), q16_value(1'b1), q16_value(1'b1), pw,
                rand_weight(), i == n - 1);
    end
  endtask

  // Stretches with and without idling on both sides
  initial begin
    calm <= 1'b0;
    forever begin
      repeat ($urandom_range(500, 2000)) @(posedge clk_i);
      calm <= 1'b1;
      repeat ($urandom_range(100, 400)) @(posedge clk_i);
      calm <= 1'b0;
    end
  end

  // Result side: random gaps, one long hold-off to back the block up
  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        n_taken++;
        gap = (n_taken == HOLD_AT) ? HOLD_CYCS : (calm ? 0 : $urandom_range(0, 7));
        if (gap != 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // Request side and verdict
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_PALETTE;
    s_axis_tlast  <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bone 63: row 0 all max, row 1 all min, row 2 picks z plus a 2.0 offset
    for (int c = 0; c < 4; c++) palette_write(BONES - 1, 0, c, 32'h7FFF_FFFF);
    for (int c = 0; c < 4; c++) palette_write(BONES - 1, 1, c, 32'h8000_0000);
    palette_write(BONES - 1, 2, 0, 32'h0000_0000);
    palette_write(BONES - 1, 2, 1, 32'h0000_0000);
    palette_write(BONES - 1, 2, 2, 32'h0001_0000);
    palette_write(BONES - 1, 2, 3, 32'h0002_0000);
    // fourth row is stored only
    palette_write(BONES - 1, 3, 3, 32'h0001_0000);
    palette_write(0, 0, 0, 32'h8000_0000);

    // dot and accumulator clamps, weight above one
    influence(BONES - 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              17'h1_FFFF, 1'b0);
    influence(BONES - 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              WEIGHT_ONE, 1'b1);
    // zero weight
    influence(BONES - 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              '0, 1'b1);
    // palette write in the middle of a vertex
    influence(BONES - 1, 32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000, 32'h0001_0000,
              17'd32768, 1'b0);
    palette_write(BONES - 1, 3, 0, 32'h7FFF_FFFF);
    influence(BONES - 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              WEIGHT_ONE, 1'b1);
    influence(BONES - 1, '0, '0, '0, '0, WEIGHT_ONE, 1'b1);

    // random part: mostly vertices over loaded bones, some loads and stray writes
    while (n_sent < N_REQS) begin
      if (usable_bones.size() < 3 || $urandom_range(0, 15) == 0) begin
        load_matrix($urandom_range(0, BONES - 1));
      end else if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          palette_write($urandom_range(0, BONES - 1), $urandom_range(0, 3),
                        $urandom_range(0, 3), q16_value(1'b1));
        end
      end else begin
        vertex();
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain, then allow for any stray result
    @(posedge clk_i);
    wait (pending_cnt == 0);
    repeat (100) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run limit
  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
